// ===== src/led_comet_chase_stepper_defines.svh =====
// Assertion macros used by the comet chase stepper controller.
// The enclosing module must have a clock named clk and an active-low reset named arst_n.
`ifndef LED_COMET_CHASE_STEPPER_DEFINES_SVH
`define LED_COMET_CHASE_STEPPER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define LCCS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define LCCS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define LCCS_ASSERT_IMP(lbl, ante, cons, msg)

`define LCCS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/lccs_pkg.sv =====
package lccs_pkg;

	localparam int MAX_LEN = 64;
	localparam logic [6:0] LEN_MAX = 7'(MAX_LEN);

	// Register indexes on the configuration port.
	localparam logic [2:0] CFG_RAMP_LENGTH   = 3'd0;
	localparam logic [2:0] CFG_TAIL_WIDTH    = 3'd1;
	localparam logic [2:0] CFG_PEAK_LEVEL    = 3'd2;
	localparam logic [2:0] CFG_STEP_INTERVAL = 3'd3;
	localparam logic [2:0] CFG_RUN_DURATION  = 3'd4;
	localparam logic [2:0] CFG_END_ACTION    = 3'd5;
	localparam logic [2:0] CFG_PATTERN_FLAGS = 3'd6;
	localparam logic [2:0] CFG_FIXED_COLOR   = 3'd7;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_TIME  = 1'b1;

	localparam logic KIND_ZONE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [1:0] END_KEEP = 2'd0;
	localparam logic [1:0] END_OFF  = 2'd1;
	localparam logic [1:0] END_ON   = 2'd2;

	localparam logic [1:0] DRAW_RED   = 2'd0;
	localparam logic [1:0] DRAW_GREEN = 2'd1;
	localparam logic [1:0] DRAW_BLUE  = 2'd2;

	localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
	localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_CHECK_STEP,
		ST_SETUP,
		ST_MUL_Q,
		ST_MUL_ND,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_COLOR,
		ST_EMIT,
		ST_END
	} ctrl_state_t;

	typedef struct packed {
		logic       take_in;
		logic       arm;
		logic       step;
		logic       setup;
		logic       mul_q;
		logic       mul_nd;
		logic       div_start;
		logic       draw;
		logic [1:0] draw_sel;
		logic       load_zone;
		logic       load_end;
		logic       next_off;
	} dp_cmd_t;

	typedef struct packed {
		logic is_start;
		logic running;
		logic expired;
		logic step_due;
		logic div_done;
		logic lvl_zero;
		logic use_fixed;
		logic last_off;
	} dp_status_t;

endpackage

// ===== src/lccs_div.sv =====
module lccs_div import lccs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [21:0] num,
	input  logic [14:0] den,
	output logic [7:0]  quo,
	output logic        done
);

	// Restoring division, one quotient bit per cycle. The caller guarantees that
	// the quotient fits in eight bits, so only eight trial subtractions are needed.
	logic        busy_q;
	logic        done_q;
	logic [2:0]  cnt_q;
	logic [21:0] rem_q;
	logic [14:0] den_q;
	logic [7:0]  quo_q;
	logic [21:0] trial;
	logic        ge;

	assign trial = {7'b0, den_q} << cnt_q;
	assign ge    = rem_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 3'd0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd7;
			end else if (busy_q) begin
				if (cnt_q == 3'd0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - trial;
			end
			quo_q <= {quo_q[6:0], ge};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

// ===== src/lccs_datapath.sv =====
module lccs_datapath import lccs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_data,
	input  logic        req_type,
	input  logic [31:0] now_ms,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	output logic        kind,
	output logic [5:0]  position,
	output logic [7:0]  level,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        color_write,
	output logic        clear_others,
	output logic [1:0]  end_code,
	output logic        last
);

	// Configuration registers.
	logic [6:0]  ramp_length_q;
	logic [7:0]  tail_width_q;
	logic [7:0]  peak_level_q;
	logic [15:0] step_interval_q;
	logic [31:0] run_duration_q;
	logic [1:0]  end_action_q;
	logic [1:0]  pattern_flags_q;
	logic [23:0] fixed_color_q;

	// Chase state.
	logic        running_q;
	logic [5:0]  head_q;
	logic [31:0] start_stamp_q;
	logic [31:0] last_stamp_q;
	logic [31:0] lfsr_q;

	// Latched request and per-step working registers.
	logic        req_q;
	logic [31:0] now_q;
	logic [6:0]  width_q;
	logic [5:0]  d_q;
	logic [5:0]  off_q;
	logic [11:0] dd_q;
	logic [11:0] q_q;
	logic [14:0] den_q;
	logic [21:0] num_q;
	logic [7:0]  red_d_q;
	logic [7:0]  green_d_q;
	logic [7:0]  blue_d_q;

	// Output payload registers.
	logic        kind_q;
	logic [5:0]  position_q;
	logic [7:0]  level_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;
	logic        color_write_q;
	logic        clear_others_q;
	logic [1:0]  end_code_q;
	logic        last_q;

	logic        rev;
	logic        fixed;
	logic [6:0]  len_c;
	logic [6:0]  lenm1;
	logic [6:0]  inc;
	logic [5:0]  head_fwd;
	logic [5:0]  head_rev;
	logic [6:0]  width_c;
	logic [6:0]  pos_r;
	logic [6:0]  pos_rev;
	logic [7:0]  pos_f;
	logic [7:0]  pos_fwd;
	logic [5:0]  pos_c;
	logic [5:0]  k_c;
	logic [6:0]  t_c;
	logic [12:0] kt_c;
	logic [11:0] dd_c;
	logic [14:0] five_dd;
	logic [19:0] pq_c;
	logic [7:0]  div_quo;
	logic        div_done;
	logic [7:0]  level_c;
	logic [31:0] lfsr_nxt;
	logic [1:0]  code_c;
	logic [7:0]  red_c;
	logic [7:0]  green_c;
	logic [7:0]  blue_c;

	function automatic logic [31:0] lfsr_step8(input logic [31:0] s);
		logic [31:0] v;
		v = s;
		for (int i = 0; i < 8; i++) begin
			if (v[0]) begin
				v = (v >> 1) ^ LFSR_MASK;
			end else begin
				v = v >> 1;
			end
		end
		return v;
	endfunction

	assign rev   = pattern_flags_q[0];
	assign fixed = pattern_flags_q[1];

	always_comb begin
		if (ramp_length_q == 7'd0) begin
			len_c = 7'd1;
		end else if (ramp_length_q > LEN_MAX) begin
			len_c = LEN_MAX;
		end else begin
			len_c = ramp_length_q;
		end
	end

	assign lenm1    = len_c - 7'd1;
	assign inc      = {1'b0, head_q} + 7'd1;
	assign head_fwd = (inc >= len_c) ? 6'd0 : inc[5:0];
	assign head_rev = (head_q == 6'd0 || {1'b0, head_q} > lenm1) ? lenm1[5:0] : head_q - 6'd1;

	always_comb begin
		if (tail_width_q == 8'd0) begin
			width_c = 7'd1;
		end else if (tail_width_q > {1'b0, len_c}) begin
			width_c = len_c;
		end else begin
			width_c = tail_width_q[6:0];
		end
	end

	// The head is always inside the ramp here, so one conditional subtract wraps.
	assign pos_r   = {1'b0, head_q} + {1'b0, off_q};
	assign pos_rev = (pos_r >= len_c) ? pos_r - len_c : pos_r;
	assign pos_f   = {2'b0, head_q} + {1'b0, len_c} - {2'b0, off_q};
	assign pos_fwd = (pos_f >= {1'b0, len_c}) ? pos_f - {1'b0, len_c} : pos_f;
	assign pos_c   = rev ? pos_rev[5:0] : pos_fwd[5:0];

	// Falloff terms: q = k * (2D - k), den = 5D^2 - q, num = 4 * peak * q.
	assign k_c     = d_q - off_q;
	assign t_c     = {d_q, 1'b0} - {1'b0, k_c};
	assign kt_c    = {7'b0, k_c} * {6'b0, t_c};
	assign dd_c    = {6'b0, d_q} * {6'b0, d_q};
	assign five_dd = {1'b0, dd_q, 2'b00} + {3'b0, dd_q};
	assign pq_c    = {12'b0, peak_level_q} * {8'b0, q_q};

	lccs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_q),
		.den    (den_q),
		.quo    (div_quo),
		.done   (div_done)
	);

	// A zone one position wide has no falloff and sits at the peak.
	assign level_c  = (d_q == 6'd0) ? peak_level_q : div_quo;
	assign lfsr_nxt = lfsr_step8(lfsr_q);
	assign code_c   = (end_action_q == END_ON || end_action_q == END_OFF) ? end_action_q : END_KEEP;

	always_comb begin
		if (level_c == 8'd0) begin
			red_c   = 8'd0;
			green_c = 8'd0;
			blue_c  = 8'd0;
		end else if (fixed) begin
			red_c   = fixed_color_q[23:16];
			green_c = fixed_color_q[15:8];
			blue_c  = fixed_color_q[7:0];
		end else begin
			red_c   = red_d_q;
			green_c = green_d_q;
			blue_c  = blue_d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_length_q   <= 7'd1;
			tail_width_q    <= 8'd3;
			peak_level_q    <= 8'd200;
			step_interval_q <= 16'd30;
			run_duration_q  <= 32'd0;
			end_action_q    <= END_KEEP;
			pattern_flags_q <= 2'd0;
			fixed_color_q   <= 24'd0;
			running_q       <= 1'b0;
			head_q          <= 6'd0;
			start_stamp_q   <= 32'd0;
			last_stamp_q    <= 32'd0;
			lfsr_q          <= LFSR_SEED;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_RAMP_LENGTH:   ramp_length_q   <= cfg_data[6:0];
					CFG_TAIL_WIDTH:    tail_width_q    <= cfg_data[7:0];
					CFG_PEAK_LEVEL:    peak_level_q    <= cfg_data[7:0];
					CFG_STEP_INTERVAL: step_interval_q <= cfg_data[15:0];
					CFG_RUN_DURATION:  run_duration_q  <= cfg_data;
					CFG_END_ACTION:    end_action_q    <= cfg_data[1:0];
					CFG_PATTERN_FLAGS: pattern_flags_q <= cfg_data[1:0];
					CFG_FIXED_COLOR:   fixed_color_q   <= cfg_data[23:0];
				endcase
			end
			if (cmd.arm) begin
				running_q     <= 1'b1;
				head_q        <= rev ? lenm1[5:0] : 6'd0;
				start_stamp_q <= now_q;
				last_stamp_q  <= now_q;
			end
			if (cmd.load_end) begin
				running_q <= 1'b0;
			end
			if (cmd.step) begin
				last_stamp_q <= now_q;
				head_q       <= rev ? head_rev : head_fwd;
			end
			if (cmd.draw) begin
				lfsr_q <= lfsr_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			req_q <= req_type;
			now_q <= now_ms;
		end
		if (cmd.step) begin
			width_q <= width_c;
			d_q     <= 6'(width_c - 7'd1);
			off_q   <= 6'd0;
		end
		if (cmd.next_off) begin
			off_q <= off_q + 6'd1;
		end
		if (cmd.setup) begin
			dd_q <= dd_c;
		end
		if (cmd.mul_q) begin
			q_q <= kt_c[11:0];
		end
		if (cmd.mul_nd) begin
			den_q <= five_dd - {3'b0, q_q};
			num_q <= {pq_c, 2'b00};
		end
		if (cmd.draw) begin
			case (cmd.draw_sel)
				DRAW_RED:   red_d_q   <= lfsr_nxt[7:0];
				DRAW_GREEN: green_d_q <= lfsr_nxt[7:0];
				default:    blue_d_q  <= lfsr_nxt[7:0];
			endcase
		end
		if (cmd.load_zone) begin
			kind_q         <= KIND_ZONE;
			position_q     <= pos_c;
			level_q        <= level_c;
			red_q          <= red_c;
			green_q        <= green_c;
			blue_q         <= blue_c;
			color_write_q  <= level_c != 8'd0;
			clear_others_q <= off_q == 6'd0;
			end_code_q     <= END_KEEP;
			last_q         <= status.last_off;
		end else if (cmd.load_end) begin
			kind_q         <= KIND_END;
			position_q     <= 6'd0;
			level_q        <= (code_c == END_ON) ? peak_level_q : 8'd0;
			red_q          <= 8'd0;
			green_q        <= 8'd0;
			blue_q         <= 8'd0;
			color_write_q  <= 1'b0;
			clear_others_q <= 1'b0;
			end_code_q     <= code_c;
			last_q         <= 1'b1;
		end
	end

	assign status.is_start  = req_q == REQ_START;
	assign status.running   = running_q;
	assign status.expired   = (run_duration_q != 32'd0) &&
	                          ((now_q - start_stamp_q) >= run_duration_q);
	assign status.step_due  = (now_q - last_stamp_q) >= {16'b0, step_interval_q};
	assign status.div_done  = div_done;
	assign status.lvl_zero  = level_c == 8'd0;
	assign status.use_fixed = fixed;
	assign status.last_off  = ({1'b0, off_q} + 7'd1) == width_q;

	assign kind         = kind_q;
	assign position     = position_q;
	assign level        = level_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign color_write  = color_write_q;
	assign clear_others = clear_others_q;
	assign end_code     = end_code_q;
	assign last         = last_q;

endmodule

// ===== src/lccs_ctrl.sv =====
`include "led_comet_chase_stepper_defines.svh"

module lccs_ctrl import lccs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic [1:0]  draw_cnt_q;
	logic        out_valid_q;
	logic        out_free;
	logic        in_take;

	assign out_free = !out_valid_q || out_ready;
	assign in_take  = in_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (status.is_start || !status.running) begin
					state_d = ST_IDLE;
				end else if (status.expired) begin
					state_d = ST_END;
				end else begin
					state_d = ST_CHECK_STEP;
				end
			end
			ST_CHECK_STEP: state_d = status.step_due ? ST_SETUP : ST_IDLE;
			ST_SETUP:      state_d = ST_MUL_Q;
			ST_MUL_Q:      state_d = ST_MUL_ND;
			ST_MUL_ND:     state_d = ST_DIV_GO;
			ST_DIV_GO:     state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (status.div_done) begin
					state_d = (status.lvl_zero || status.use_fixed) ? ST_EMIT : ST_COLOR;
				end
			end
			ST_COLOR: begin
				if (draw_cnt_q == DRAW_BLUE) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = status.last_off ? ST_IDLE : ST_MUL_Q;
				end
			end
			ST_END: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:       cmd.take_in = in_valid;
			ST_DISPATCH:   cmd.arm = status.is_start;
			ST_CHECK_STEP: cmd.step = status.step_due;
			ST_SETUP:      cmd.setup = 1'b1;
			ST_MUL_Q:      cmd.mul_q = 1'b1;
			ST_MUL_ND:     cmd.mul_nd = 1'b1;
			ST_DIV_GO:     cmd.div_start = 1'b1;
			ST_COLOR: begin
				cmd.draw     = 1'b1;
				cmd.draw_sel = draw_cnt_q;
			end
			ST_EMIT: begin
				cmd.load_zone = out_free;
				cmd.next_off  = out_free && !status.last_off;
			end
			ST_END:        cmd.load_end = out_free;
			default:       cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			draw_cnt_q  <= DRAW_RED;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			draw_cnt_q <= (state_q == ST_COLOR) ? draw_cnt_q + 2'd1 : DRAW_RED;
			if (cmd.load_zone || cmd.load_end) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	`LCCS_ASSERT_IMP(a_load_slot_free, cmd.load_zone || cmd.load_end, !out_valid_q || out_ready, "result loaded over a pending one")
	`LCCS_ASSERT_IMP(a_div_done_wait, status.div_done, state_q == ST_DIV_WAIT, "divider finished outside its wait state")
	`LCCS_ASSERT_IMP(a_color_random, state_q == ST_COLOR, !status.lvl_zero && !status.use_fixed, "colour drawn for a dark or fixed entry")
	`LCCS_ASSERT_NXT(a_take_dispatch, in_take, state_q == ST_DISPATCH, "accepted request not dispatched")

endmodule

// ===== src/led_comet_chase_stepper.sv =====
// Comet chase stepper: steps a wrapping comet over a ramp of up to 64 positions.
// Requests arrive on the in channel (in_valid/in_ready) carrying req_type and now_ms.
// A start request arms the ramp and produces no result; a time request either ends
// the run with one end result, does nothing when the chase is stopped or no step is due,
// or moves the head and produces one zone result per tail position, head first, the last one flagged.
// Results leave on the out channel (out_valid/out_ready) from an output register.
// Configuration is written through cfg_we/cfg_addr/cfg_data, one register per edge;
// write it only while no request is in flight. The block itself does not enforce this.
// Flow: a request is taken only while the controller is idle. A start, or a time
// request while the chase is idle, returns to idle from the dispatch state, and a
// step not yet due returns from the check-step state after it; an end result is loaded
// from the end state once the output register is free. A step runs a setup state, then
// per zone entry two multiply states, a division in the divider that shapes each level,
// and the emit state; entries with random colour first draw one byte per colour from
// the LFSR, while those with fixed colour or level zero skip that draw.
// When the receiver stalls, the controller holds in its emit state with the next
// entry computed and resumes as soon as the output register frees up; a request
// can still be accepted while the final result of the previous one waits there.
// Reset returns the configuration and chase registers to their reset values, the block to idle,
// and the colour generator to its seed; no result is pending afterward.
module led_comet_chase_stepper import lccs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [5:0]  position,
	output logic [7:0]  level,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        color_write,
	output logic        clear_others,
	output logic [1:0]  end_code,
	output logic        last
);

	// Command and status between the controller and the datapath.
	dp_cmd_t    cmd;
	dp_status_t status;

	lccs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the registers, the chase state, the falloff arithmetic
	// with its divider, the colour generator and the output payload register.
	lccs_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.req_type     (req_type),
		.now_ms       (now_ms),
		.cmd          (cmd),
		.status       (status),
		.kind         (kind),
		.position     (position),
		.level        (level),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.color_write  (color_write),
		.clear_others (clear_others),
		.end_code     (end_code),
		.last         (last)
	);

endmodule
